// ===== rtl/integer_set_table_macros.svh =====
// assertion macros shared by the integer set table rtl
// no dependencies; taken in by the files that carry assertions
`ifndef INTEGER_SET_TABLE_MACROS_SVH
`define INTEGER_SET_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define IST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define IST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ist_pkg.sv =====
// types and constants of the integer set table
// no dependencies
package ist_pkg;

   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_MIN    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY_MIN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_WRITE
   } state_type;

   // one table slot as stored in memory
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   // controller strobes
   typedef struct packed {
      logic req_ready;
      logic scan_start;
      logic rd_en;
      logic consume;
      logic clear_wr;
      logic upd_wr;
      logic rsp_load;
   } ctl_type;

   // outcome of a finished scan
   typedef struct packed {
      logic                      found;
      logic                      do_write;
      logic                      wr_valid;
      logic                      nonempty;
      logic signed [VALUE_W-1:0] min_value;
      status_type                status;
   } scan_sum_type;

endpackage

// ===== rtl/ist_channels.sv =====
// request and response channel interfaces of the integer set table
// depends on ist_pkg
interface ist_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        req_type;
   logic signed [ist_pkg::VALUE_W-1:0] value;

   modport source (output valid, req_type, value, input ready);
   modport sink (input valid, req_type, value, output ready);
endinterface

interface ist_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic signed [ist_pkg::VALUE_W-1:0] min_value;
   logic                              is_empty;
   logic [1:0]                        status;

   modport source (output valid, found, min_value, is_empty, status, input ready);
   modport sink (input valid, found, min_value, is_empty, status, output ready);
endinterface

// ===== rtl/ist_store.sv =====
// slot memory of the integer set table: one write port, one registered read port
// depends on ist_pkg
module ist_store #(
   parameter int CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(CAPACITY)-1:0]          wr_idx,
   input  ist_pkg::entry_type                   wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(CAPACITY)-1:0]          rd_idx,
   output ist_pkg::entry_type                   rd_data
);

   ist_pkg::entry_type slot_mem [CAPACITY];
   ist_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ist_scan.sv =====
// scan accumulator: match, lowest free slot and minimum over streamed slots
// depends on ist_pkg
module ist_scan #(
   parameter int CAPACITY = 16
) (
   input  logic                                 clock,
   input  ist_pkg::ctl_type                     ctl,
   input  ist_pkg::req_code_type                req_code,
   input  logic signed [ist_pkg::VALUE_W-1:0]   req_value,
   input  ist_pkg::entry_type                   entry,
   input  logic [$clog2(CAPACITY)-1:0]          entry_idx,
   output ist_pkg::scan_sum_type                sum,
   output logic [$clog2(CAPACITY)-1:0]          wr_idx
);

   localparam int IDX_W = $clog2(CAPACITY);

   logic                              hit_ff, hit_in;
   logic [IDX_W-1:0]                  hit_idx_ff, hit_idx_in;
   logic                              free_ff, free_in;
   logic [IDX_W-1:0]                  free_idx_ff, free_idx_in;
   logic                              have_ff, have_in;
   logic signed [ist_pkg::VALUE_W-1:0] best_ff, best_in;
   logic                              match;
   logic                              added;
   logic                              full;
   logic                              removed;

   assign match = entry.valid && (entry.value == req_value);

   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      have_in     = have_ff;
      best_in     = best_ff;
      if (ctl.scan_start) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
         have_in = 1'b0;
      end else if (ctl.consume) begin
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = entry_idx;
         end
         if (!entry.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = entry_idx;
         end
         // a slot about to be removed takes no part in the minimum
         if (entry.valid && !(match && req_code == ist_pkg::REQ_REMOVE)) begin
            if (!have_ff || entry.value < best_ff) begin
               best_in = entry.value;
            end
            have_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
   end

   assign added   = (req_code == ist_pkg::REQ_ADD) && !hit_ff && free_ff;
   assign full    = (req_code == ist_pkg::REQ_ADD) && !hit_ff && !free_ff;
   assign removed = (req_code == ist_pkg::REQ_REMOVE) && hit_ff;

   always_comb begin
      sum.found    = hit_ff && (req_code != ist_pkg::REQ_MIN);
      sum.do_write = added || removed;
      sum.wr_valid = added;
      sum.nonempty = have_ff || added;
      if (added && (!have_ff || req_value < best_ff)) begin
         sum.min_value = req_value;
      end else if (have_ff) begin
         sum.min_value = best_ff;
      end else begin
         sum.min_value = '0;
      end
      if (full) begin
         sum.status = ist_pkg::ST_FULL;
      end else if (req_code == ist_pkg::REQ_MIN && !have_ff) begin
         sum.status = ist_pkg::ST_EMPTY_MIN;
      end else begin
         sum.status = ist_pkg::ST_OK;
      end
   end

   assign wr_idx = added ? free_idx_ff : hit_idx_ff;

endmodule

// ===== rtl/ist_ctrl.sv =====
// sequencer: clearing pass, slot scan, write-back and response hand-off
// depends on ist_pkg
module ist_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 rsp_free,
   output ist_pkg::ctl_type                     ctl,
   output logic [$clog2(CAPACITY)-1:0]          slot_idx,
   output logic [$clog2(CAPACITY)-1:0]          data_idx
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   ist_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_tag_ff;
   logic               at_last;

   assign at_last = (cnt_ff == LAST_IDX);

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      unique case (state_ff)
         ist_pkg::S_CLEAR: begin
            cnt_in = at_last ? '0 : cnt_ff + 1'b1;
            if (at_last) begin
               state_in = ist_pkg::S_IDLE;
            end
         end
         ist_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ist_pkg::S_SCAN;
            end
         end
         ist_pkg::S_SCAN: begin
            cnt_in = at_last ? '0 : cnt_ff + 1'b1;
            if (at_last) begin
               state_in = ist_pkg::S_LAST;
            end
         end
         ist_pkg::S_LAST: begin
            state_in = ist_pkg::S_WRITE;
         end
         ist_pkg::S_WRITE: begin
            if (rsp_free) begin
               state_in = ist_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ist_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl         = '0;
      ctl.consume = rd_vld_ff;
      unique case (state_ff)
         ist_pkg::S_CLEAR: begin
            ctl.clear_wr = 1'b1;
         end
         ist_pkg::S_IDLE: begin
            ctl.req_ready  = 1'b1;
            ctl.scan_start = req_valid;
         end
         ist_pkg::S_SCAN: begin
            ctl.rd_en = 1'b1;
         end
         ist_pkg::S_LAST: begin
            ctl.rd_en = 1'b0;
         end
         ist_pkg::S_WRITE: begin
            ctl.upd_wr   = 1'b1;
            ctl.rsp_load = rsp_free;
         end
         default: begin
            ctl.rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ist_pkg::S_CLEAR;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= ctl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff <= cnt_ff;
   end

   assign slot_idx = cnt_ff;
   assign data_idx = rd_tag_ff;

endmodule

// ===== rtl/integer_set_table.sv =====
// integer set table: a bounded set of distinct signed 32-bit integers. A request
// transaction adds a value (no change if already present), removes a value, asks
// whether a value is present, or asks for the smallest member; each one gives exactly
// one response transaction with presence before the request, minimum and emptiness
// after it, and a status (ok, table full on add, minimum of an empty set). Members
// live in a slot memory of CAPACITY entries, each with its own valid bit, that has one
// write port and one read port, and an add takes the lowest free slot. Every request is
// served by one full pass over the memory, one slot read a cycle: the request is
// accepted, every slot is read, the last read returns and the result is written back.
// Only one request is in flight; a response may wait in its output register while the
// next request is taken. After reset the memory is swept once to clear the valid bits,
// during which no request is accepted.
// depends on ist_pkg, ist_channels, ist_ctrl, ist_scan, ist_store and the macro header
`include "integer_set_table_macros.svh"

module integer_set_table #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   ist_req_if.sink    req_ch,
   ist_rsp_if.source  rsp_ch
);

   localparam int IDX_W = $clog2(CAPACITY);

   ist_pkg::ctl_type                   ctl;
   ist_pkg::scan_sum_type              sum;
   ist_pkg::entry_type                 rd_data;
   ist_pkg::entry_type                 wr_data;
   logic [IDX_W-1:0]                   slot_idx;
   logic [IDX_W-1:0]                   data_idx;
   logic [IDX_W-1:0]                   upd_idx;
   logic [IDX_W-1:0]                   wr_idx;
   logic                               wr_en;
   logic                               rsp_free;
   logic                               req_accept;

   // latched request
   ist_pkg::req_code_type              req_code_ff;
   logic signed [ist_pkg::VALUE_W-1:0] req_value_ff;

   // response register
   logic                               rsp_valid_ff;
   logic                               rsp_found_ff;
   logic signed [ist_pkg::VALUE_W-1:0] rsp_min_ff;
   logic                               rsp_empty_ff;
   ist_pkg::status_type                rsp_status_ff;

   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept = req_ch.valid && ctl.req_ready;

   ist_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_free  (rsp_free),
      .ctl       (ctl),
      .slot_idx  (slot_idx),
      .data_idx  (data_idx)
   );

   ist_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock     (clock),
      .ctl       (ctl),
      .req_code  (req_code_ff),
      .req_value (req_value_ff),
      .entry     (rd_data),
      .entry_idx (data_idx),
      .sum       (sum),
      .wr_idx    (upd_idx)
   );

   // clearing pass writes invalid slots; write-back is repeated harmlessly on a stall
   assign wr_en         = ctl.clear_wr || (ctl.upd_wr && sum.do_write);
   assign wr_idx        = ctl.clear_wr ? slot_idx : upd_idx;
   assign wr_data.valid = ctl.clear_wr ? 1'b0 : sum.wr_valid;
   assign wr_data.value = req_value_ff;

   ist_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_idx  (slot_idx),
      .rd_data (rd_data)
   );

   // request capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_code_ff  <= ist_pkg::req_code_type'(req_ch.req_type);
         req_value_ff <= req_ch.value;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_found_ff  <= sum.found;
         rsp_min_ff    <= sum.min_value;
         rsp_empty_ff  <= !sum.nonempty;
         rsp_status_ff <= sum.status;
      end
   end

   assign req_ch.ready     = ctl.req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.found     = rsp_found_ff;
   assign rsp_ch.min_value = rsp_min_ff;
   assign rsp_ch.is_empty  = rsp_empty_ff;
   assign rsp_ch.status    = rsp_status_ff;

   // an accepted transaction starts its slot scan in the next cycle
   `IST_ASSERT_NEXT(a_scan_follows_accept, clock, reset, req_accept, ctl.rd_en, "scan did not start")

   // memory reads and writes never share a cycle
   `IST_ASSERT_NOW(a_no_rd_wr_overlap, clock, reset, wr_en, !ctl.rd_en, "read during write")

   // a full flag only comes from an add of an absent value
   `IST_ASSERT_NOW(a_full_only_on_add, clock, reset, ctl.rsp_load && sum.status == ist_pkg::ST_FULL, req_code_ff == ist_pkg::REQ_ADD && !sum.found, "bad full status")

   // an empty set reports a zero minimum
   `IST_ASSERT_NOW(a_empty_min_zero, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_min_ff == '0, "nonzero minimum of empty set")

endmodule

// ===== tb/sv/integer_set_table_checker.sv =====
// response checker for the integer set table: watches both channels, keeps its own
// copy of the set and compares every response transaction with the prediction
// depends on ist_pkg and the channel interfaces in ist_channels
`timescale 1ns / 100ps

module set_table_checker
   import ist_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic clock,
   input  logic reset,
   ist_req_if   req_mon,
   ist_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_count,
   output int   checked_count,
   output int   full_count,
   output int   empty_min_count
);

   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] min_value;
      logic                      is_empty;
      status_type                status;
   } set_result_t;

   set_result_t               outcome_q[$];
   logic signed [VALUE_W-1:0] member_value [CAPACITY];
   logic                      member_used  [CAPACITY];
   int                        errors     = 0;
   int                        checked    = 0;
   int                        fulls      = 0;
   int                        empty_mins = 0;

   // applies one request to the set copy and returns the response it should give
   function automatic set_result_t apply_request(req_code_type kind,
                                                 logic signed [VALUE_W-1:0] v);
      set_result_t               r;
      int                        hit;
      int                        free_idx;
      logic                      have;
      logic signed [VALUE_W-1:0] lowest;
      hit      = -1;
      free_idx = -1;
      have     = 1'b0;
      lowest   = '0;
      r        = '0;
      r.status = ST_OK;
      if (kind != REQ_MIN) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (member_used[i] && member_value[i] == v && hit < 0) hit = i;
            if (!member_used[i] && free_idx < 0) free_idx = i;
         end
         r.found = (hit >= 0);
         if (kind == REQ_ADD && hit < 0) begin
            if (free_idx >= 0) begin
               member_value[free_idx] = v;
               member_used[free_idx]  = 1'b1;
            end else begin
               r.status = ST_FULL;
            end
         end else if (kind == REQ_REMOVE && hit >= 0) begin
            member_used[hit] = 1'b0;
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (member_used[i]) begin
            if (!have || member_value[i] < lowest) lowest = member_value[i];
            have = 1'b1;
         end
      end
      r.min_value = lowest;
      r.is_empty  = !have;
      if (kind == REQ_MIN && !have) r.status = ST_EMPTY_MIN;
      return r;
   endfunction

   always @(posedge clock) begin
      set_result_t want;
      if (reset) begin
         outcome_q.delete();
         for (int i = 0; i < CAPACITY; i++) member_used[i] = 1'b0;
      end else begin
         // responses first: a response never belongs to a request taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] unexpected response: found=%0b min=%0d empty=%0b status=%0d",
                           $realtime, rsp_mon.found, rsp_mon.min_value, rsp_mon.is_empty,
                           rsp_mon.status);
            end else begin
               want = outcome_q.pop_front();
               checked++;
               if (want.status == ST_FULL) fulls++;
               if (want.status == ST_EMPTY_MIN) empty_mins++;
               if (rsp_mon.found !== want.found || rsp_mon.min_value !== want.min_value ||
                   rsp_mon.is_empty !== want.is_empty || rsp_mon.status !== want.status) begin
                  errors++;
                  if (errors <= 10)
                     $display({"[%0t] response %0d mismatch: expected found=%0b min=%0d ",
                               "empty=%0b status=%0d, got found=%0b min=%0d empty=%0b status=%0d"},
                              $realtime, checked, want.found, want.min_value, want.is_empty,
                              want.status, rsp_mon.found, rsp_mon.min_value, rsp_mon.is_empty,
                              rsp_mon.status);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            outcome_q.push_back(apply_request(req_code_type'(req_mon.req_type), req_mon.value));
      end
      error_count     <= errors;
      pending_count   <= outcome_q.size();
      checked_count   <= checked;
      full_count      <= fulls;
      empty_min_count <= empty_mins;
   end

endmodule

// ===== tb/sv/integer_set_table_tb.sv =====
// top of the integer set table testbench: clock, reset, request stimulus, response
// back-pressure and the verdict; prediction and comparison sit in set_table_checker
// depends on ist_pkg, ist_channels, integer_set_table and set_table_checker
`timescale 1ns / 100ps

module integer_set_table_tb;
   import ist_pkg::*;

   localparam int CAPACITY        = 16;
   localparam int LATENCY         = CAPACITY + 3;
   localparam int RANDOM_ITEMS    = 1600;
   localparam int POOL_SIZE       = 20;
   localparam int HOLD_OFF_AT     = 500;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 400000;

   localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   logic clock = 1'b0;
   logic reset;

   ist_req_if req_ch ();
   ist_rsp_if rsp_ch ();

   int error_count;
   int pending_count;
   int checked_count;
   int full_count;
   int empty_min_count;

   // transaction bookkeeping shared by the sender and the receiver
   int sent_count  = 0;
   int burst_left  = 0;
   int add_count   = 0;
   int remove_count = 0;
   int query_count = 0;
   int min_count   = 0;
   int cycle_count = 0;

   // values the random sequences draw from, so that adds, removes and lookups hit
   logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

   integer_set_table #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   set_table_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .full_count      (full_count),
      .empty_min_count (empty_min_count)
   );

   always #2 clock = ~clock;

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  pending_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // offer one request transaction and hold it until the block takes it; the sender
   // works in bursts, and a gap between bursts drops valid for a random stretch
   task automatic offer(req_code_type kind, logic signed [VALUE_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= 2'($urandom);
            req_ch.value    <= $urandom;
            repeat (gap) @(posedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.value    <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
      case (kind)
         REQ_ADD:    add_count++;
         REQ_REMOVE: remove_count++;
         REQ_QUERY:  query_count++;
         default:    min_count++;
      endcase
   endtask

   // fresh lookup values: mostly wide random patterns, some extremes and small numbers
   task automatic refill_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         case ($urandom_range(0, 9))
            0:       value_pool[i] = $urandom_range(0, 1) ? MOST_NEGATIVE : MOST_POSITIVE;
            1:       value_pool[i] = $urandom_range(0, 1) ? MOST_NEGATIVE + $urandom_range(1, 3)
                                                          : MOST_POSITIVE - $urandom_range(1, 3);
            2, 3:    value_pool[i] = $signed($urandom_range(0, 20)) - 10;
            default: value_pool[i] = $urandom;
         endcase
      end
   endtask

   // request kind from percentage weights; what is left over goes to the minimum query
   function automatic req_code_type pick_kind(int w_add, int w_remove, int w_query);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < w_add) return REQ_ADD;
      if (roll < w_add + w_remove) return REQ_REMOVE;
      if (roll < w_add + w_remove + w_query) return REQ_QUERY;
      return REQ_MIN;
   endfunction

   // receiver: stalls on phases of its own, plus one long hold-off so that the
   // output register fills and the block pushes back on the request side
   initial begin : rsp_pacing
      int  mode;
      int  phase_left;
      bit  held_off;
      held_off   = 1'b0;
      phase_left = 0;
      mode       = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && sent_count >= HOLD_OFF_AT) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (phase_left == 0) begin
               mode       = $urandom_range(0, 3);
               phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;                          // no stalls
               1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);   // light stalls
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);   // heavy stalls
               default: rsp_ch.ready <= (phase_left % 8) < 3;          // regular pattern
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int           random_sent;
      int           episode_left;
      int           episode;
      req_code_type kind;
      logic signed [VALUE_W-1:0] v;
      random_sent = 0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_ADD;
      req_ch.value    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part: empty set cases, extremes, duplicates, removal of slot zero
      offer(REQ_MIN, 32'sd0);              // minimum of an empty set
      offer(REQ_QUERY, 32'sd5);            // lookup on an empty set
      offer(REQ_REMOVE, 32'sd5);           // remove of an absent value
      offer(REQ_ADD, MOST_POSITIVE);       // lands in the first slot
      offer(REQ_ADD, MOST_NEGATIVE);
      offer(REQ_ADD, 32'sd0);
      offer(REQ_ADD, -32'sd1);
      offer(REQ_ADD, MOST_POSITIVE);       // add of a present value
      offer(REQ_QUERY, MOST_NEGATIVE);
      offer(REQ_QUERY, 32'sd1);
      offer(REQ_MIN, MOST_POSITIVE);
      offer(REQ_REMOVE, MOST_POSITIVE);    // removes the first slot's member
      offer(REQ_MIN, 32'sd0);
      offer(REQ_ADD, 32'sd42);             // reuses the freed first slot
      offer(REQ_REMOVE, 32'sd7);
      offer(REQ_REMOVE, MOST_NEGATIVE);    // removes the current minimum
      offer(REQ_MIN, 32'sd0);
      offer(REQ_REMOVE, 32'sd0);
      offer(REQ_REMOVE, -32'sd1);
      offer(REQ_REMOVE, 32'sd42);          // set empties again
      offer(REQ_QUERY, 32'sd42);
      offer(REQ_MIN, 32'sd0);
      offer(REQ_ADD, 32'sh5555_5555);
      offer(REQ_ADD, 32'shAAAA_AAAA);
      offer(REQ_MIN, 32'sd0);

      // random part: episodes that fill the table, drain it, mix, or throw noise
      refill_pool();
      while (random_sent < RANDOM_ITEMS) begin
         episode      = $urandom_range(0, 9);
         episode_left = $urandom_range(20, 60);
         if ($urandom_range(0, 3) == 0) refill_pool();
         while (episode_left > 0 && random_sent < RANDOM_ITEMS) begin
            v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            case (episode)
               0, 1, 2, 3: kind = pick_kind(65, 10, 15);   // filling, reaches a full table
               4, 5, 6:    kind = pick_kind(15, 55, 15);   // draining, reaches an empty set
               7, 8:       kind = pick_kind(25, 25, 25);
               default: begin                              // noise
                  kind = req_code_type'($urandom_range(0, 3));
                  if ($urandom_range(0, 1)) v = $urandom;
               end
            endcase
            if (kind == REQ_MIN && $urandom_range(0, 1)) v = $urandom;  // ignored field
            offer(kind, v);
            random_sent++;
            episode_left--;
         end
      end
      req_ch.valid <= 1'b0;

      // let the checker count the last transaction, drain, then allow a stray
      // response the time to show itself
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);

      $display("covered %0d adds, %0d removes, %0d lookups and %0d minimum queries",
               add_count, remove_count, query_count, min_count);
      $display("%0d responses checked, %0d adds refused by a full table, %0d minima %s",
               checked_count, full_count, empty_min_count, "of an empty set");
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
